// ===== rtl/lruc_pkg.sv =====
// Shared constants, types and state codes for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lruc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned CAP_W   = 5;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W-1:0] age_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic touch;
    logic insert;
    idx_t idx;
  } rank_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/lruc_rank.sv =====
// Valid bits, recency ranks and fill count of the cache entries.
`timescale 1ns / 1ps
`default_nettype none
module lruc_rank import lruc_pkg::*; (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  rank_cmd_t                      cmd_i,
  output logic [ENTRIES-1:0]             valid_o,
  output logic [ENTRIES-1:0][IDX_W-1:0]  ages_o,
  output logic [CNT_W-1:0]               used_o
);

  logic [ENTRIES-1:0]            valid_q, valid_d;
  logic [ENTRIES-1:0][IDX_W-1:0] ages_q, ages_d;
  logic [CNT_W-1:0]              used_q, used_d;
  age_t                          sel_age;

  assign sel_age = ages_q[cmd_i.idx];

  always_comb begin
    valid_d = valid_q;
    ages_d  = ages_q;
    used_d  = used_q;
    if (cmd_i.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (ages_q[i] < sel_age)) begin
          ages_d[i] = ages_q[i] + age_t'(1);
        end
      end
      ages_d[cmd_i.idx] = '0;
    end else if (cmd_i.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i]) begin
          ages_d[i] = ages_q[i] + age_t'(1);
        end
      end
      ages_d[cmd_i.idx]  = '0;
      valid_d[cmd_i.idx] = 1'b1;
      used_d             = used_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ages_q  <= '0;
      used_q  <= '0;
    end else begin
      valid_q <= valid_d;
      ages_q  <= ages_d;
      used_q  <= used_d;
    end
  end

  assign valid_o = valid_q;
  assign ages_o  = ages_q;
  assign used_o  = used_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == CNT_W'($countones(valid_q)))
    else $error("fill count differs from number of valid entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> !valid_q[cmd_i.idx])
    else $error("insert into an occupied entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.touch |-> valid_q[cmd_i.idx])
    else $error("touch of an empty entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.touch || cmd_i.insert) |=> (ages_q[$past(cmd_i.idx)] == '0))
    else $error("touched entry is not most recent");

endmodule
`default_nettype wire

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the LRU key-value cache: scan sequencer, key/value memory, result register.
// A transaction is accepted in idle, scanned over the 16 entries, given one compare drain step,
// then updated; the update waits while an earlier result is unaccepted. No new input is taken
// before that update; the single key compare steps through the memory, one read per cycle.
// A result waits in an output register; the next input is taken while it waits.
// Reset clears valid bits, ranks, fill count and control; capacity resets to 16.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache_top import lruc_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire              action_i,
  input  wire [KEY_W-1:0]  lookup_key_i,
  input  wire [VAL_W-1:0]  store_value_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic             found_o,
  output logic [VAL_W-1:0] read_value_o,
  input  wire              cfg_we_i,
  input  wire [CAP_W-1:0]  cfg_wdata_i
);

  state_e                        state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          act_q;
  logic [KEY_W-1:0]              key_q;
  logic [VAL_W-1:0]              val_q;
  logic [CAP_W-1:0]              cap_q;
  logic [CNT_W-1:0]              cap_eff;

  logic [KEY_W-1:0]              key_mem [ENTRIES];
  logic [VAL_W-1:0]              val_mem [ENTRIES];
  logic [KEY_W-1:0]              key_rd_q;
  logic [VAL_W-1:0]              val_rd_q;
  logic                          cmp_vld_q;
  idx_t                          cmp_idx_q;
  idx_t                          scan_idx;
  logic                          issue;
  logic                          match;

  logic                          hit_q, free_q, old_q;
  idx_t                          hit_idx_q, free_idx_q, old_idx_q;
  logic [VAL_W-1:0]              hit_val_q;

  logic                          mem_we, mem_wkey;
  idx_t                          mem_waddr;
  logic                          fire;
  logic                          out_valid_q, found_q;
  logic [VAL_W-1:0]              read_value_q;
  rank_cmd_t                     rank_cmd;

  logic [ENTRIES-1:0]            valid;
  logic [ENTRIES-1:0][IDX_W-1:0] ages;
  logic [CNT_W-1:0]              used;

  lruc_rank u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (rank_cmd),
    .valid_o (valid),
    .ages_o  (ages),
    .used_o  (used)
  );

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CNT_W'(cap_q) > CNT_W'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign scan_idx   = cnt_q[IDX_W-1:0];
  assign in_ready_o = (state_q == ST_IDLE);
  assign match      = cmp_vld_q && valid[cmp_idx_q] && (key_rd_q == key_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    issue     = 1'b0;
    fire      = 1'b0;
    mem_we    = 1'b0;
    mem_wkey  = 1'b0;
    mem_waddr = hit_idx_q;
    rank_cmd  = '{touch: 1'b0, insert: 1'b0, idx: hit_idx_q};
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == CNT_W'(ENTRIES)) begin
          state_d = ST_UPDATE;
        end else begin
          issue = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          fire    = 1'b1;
          state_d = ST_IDLE;
          if (hit_q) begin
            rank_cmd.touch = 1'b1;
            mem_we         = (act_q == ACT_PUT);
          end else if (act_q == ACT_PUT) begin
            if ((used >= cap_eff) && old_q) begin
              mem_we         = 1'b1;
              mem_wkey       = 1'b1;
              mem_waddr      = old_idx_q;
              rank_cmd.touch = 1'b1;
              rank_cmd.idx   = old_idx_q;
            end else if (free_q) begin
              mem_we          = 1'b1;
              mem_wkey        = 1'b1;
              mem_waddr       = free_idx_q;
              rank_cmd.insert = 1'b1;
              rank_cmd.idx    = free_idx_q;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cap_q       <= CAP_W'(16);
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      old_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= issue;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (state_q == ST_IDLE) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        old_q  <= 1'b0;
      end else begin
        if (match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (issue && !valid[scan_idx] && !free_q) begin
          free_q <= 1'b1;
        end
        if (issue && valid[scan_idx]
            && ({1'b0, ages[scan_idx]} == (used - CNT_W'(1)))) begin
          old_q <= 1'b1;
        end
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_idx;
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      key_q <= lookup_key_i;
      val_q <= store_value_i;
    end
    if (match && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_val_q <= val_rd_q;
    end
    if (issue && !valid[scan_idx] && !free_q) begin
      free_idx_q <= scan_idx;
    end
    if (issue && valid[scan_idx]
        && ({1'b0, ages[scan_idx]} == (used - CNT_W'(1)))) begin
      old_idx_q <= scan_idx;
    end
    if (fire) begin
      found_q      <= hit_q && (act_q == ACT_GET);
      read_value_q <= (hit_q && (act_q == ACT_GET)) ? hit_val_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[mem_waddr] <= val_q;
      if (mem_wkey) begin
        key_mem[mem_waddr] <= key_q;
      end
    end
    key_rd_q <= key_mem[scan_idx];
    val_rd_q <= val_mem[scan_idx];
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !(rank_cmd.touch && rank_cmd.insert))
    else $error("touch and insert in the same update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && act_q == ACT_PUT && !hit_q) |-> (old_q || free_q))
    else $error("put of a new key finds neither oldest nor free entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPDATE) |-> !fire)
    else $error("result produced outside the update step");

endmodule
`default_nettype wire

// ===== tb/lru_key_value_cache_top_tb.sv =====
// Testbench for the LRU key-value cache: directed and random get/put traffic.
`timescale 1ns / 1ps
module lru_key_value_cache_top_tb;
  import lruc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } lookup_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             action_i = ACT_GET;
  logic [KEY_W-1:0] lookup_key_i = '0;
  logic [VAL_W-1:0] store_value_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             found_o;
  logic [VAL_W-1:0] read_value_o;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;

  lru_key_value_cache_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .lookup_key_i  (lookup_key_i),
    .store_value_i (store_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .read_value_o  (read_value_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predictor state
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0] slot_value [ENTRIES];
  logic             slot_valid [ENTRIES];
  int               slot_rank  [ENTRIES];
  int               fill_count;
  logic [CAP_W-1:0] capacity_reg;

  lookup_result_t pending_results[$];
  int             mismatch_count;
  int             burst_left;
  int             cycle_count;
  int             stall_timer;
  int             stall_mode;

  function automatic void promote_slot(input int idx);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_rank[i] < slot_rank[idx]) slot_rank[i]++;
    end
    slot_rank[idx] = 0;
  endfunction

  function automatic lookup_result_t predict_access(input logic act,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] val);
    lookup_result_t res;
    int hit;
    int victim;
    int cap;
    int i;
    res = '0;
    hit = -1;
    victim = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
    end
    if (act == ACT_GET) begin
      if (hit >= 0) begin
        promote_slot(hit);
        res.found = 1'b1;
        res.value = slot_value[hit];
      end
      return res;
    end
    if (hit >= 0) begin
      slot_value[hit] = val;
      promote_slot(hit);
      return res;
    end
    cap = (capacity_reg == 0) ? 1 : ((capacity_reg > ENTRIES) ? ENTRIES : capacity_reg);
    if (fill_count >= cap) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
      end
      if (victim >= 0) begin
        slot_key[victim] = key;
        slot_value[victim] = val;
        promote_slot(victim);
        return res;
      end
    end
    for (i = 0; i < ENTRIES; i++) begin
      if (!slot_valid[i]) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (slot_valid[j]) slot_rank[j]++;
        end
        slot_valid[i] = 1'b1;
        slot_key[i] = key;
        slot_value[i] = val;
        slot_rank[i] = 0;
        fill_count++;
        break;
      end
    end
    return res;
  endfunction

  task automatic send_request(input logic act, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    lookup_key_i  <= key;
    store_value_i <= val;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_results.push_back(predict_access(act, key, val));
    burst_left--;
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic test_extremes();
    drain_and_settle();
    set_capacity(5'd16);
    send_request(ACT_GET, 16'h0000, 31'h7FFF_FFFF);
    send_request(ACT_PUT, 16'h0000, 31'h0000_0000);
    send_request(ACT_PUT, 16'hFFFF, 31'h7FFF_FFFF);
    send_request(ACT_GET, 16'hFFFF, 31'h0000_0000);
    send_request(ACT_GET, 16'h0000, 31'h7FFF_FFFF);
    send_request(ACT_PUT, 16'h0000, 31'h5555_5555);
    send_request(ACT_GET, 16'h0000, 31'h0000_0000);
    send_request(ACT_GET, 16'h0001, 31'h0000_0000);
  endtask

  task automatic test_eviction();
    drain_and_settle();
    set_capacity(5'd2);
    send_request(ACT_PUT, 16'h00A0, 31'h2AAA_AAAA);
    send_request(ACT_GET, 16'h00A0, 31'h0000_0000);
    send_request(ACT_PUT, 16'h00B0, 31'h1234_5678);
    send_request(ACT_GET, 16'hFFFF, 31'h0000_0000);
    send_request(ACT_GET, 16'h00A0, 31'h0000_0000);
  endtask

  task automatic test_capacity_bounds();
    drain_and_settle();
    set_capacity(5'd0);
    send_request(ACT_PUT, 16'h8000, 31'h4000_0000);
    send_request(ACT_PUT, 16'h8001, 31'h0000_0001);
    send_request(ACT_GET, 16'h8000, 31'h0000_0000);
    send_request(ACT_GET, 16'h8001, 31'h0000_0000);
    drain_and_settle();
    set_capacity(5'd31);
    send_request(ACT_PUT, 16'h7FFF, 31'h3C3C_3C3C);
    send_request(ACT_PUT, 16'h8002, 31'h0F0F_0F0F);
    send_request(ACT_GET, 16'h8001, 31'h0000_0000);
    send_request(ACT_GET, 16'h7FFF, 31'h0000_0000);
  endtask

  task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int count);
    int eff;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    drain_and_settle();
    set_capacity(cap);
    eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
    base = KEY_W'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) key = KEY_W'($urandom);
      else key = base + KEY_W'($urandom_range(0, eff + 1));
      send_request(1'($urandom_range(0, 1)), key, VAL_W'($urandom));
    end
  endtask

  // Check results and drive the receiver's stall pattern
  always @(posedge clk_i) begin
    lookup_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: found=%0b value=%h", found_o, read_value_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (found_o !== exp_res.found || read_value_o !== exp_res.value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected found=%0b value=%h, actual found=%0b value=%h",
                     exp_res.found, exp_res.value, found_o, read_value_o);
        end
      end
    end
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_timer = $urandom_range(20, 120);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready_i <= (stall_timer % 4 == 0);
      end
      default: begin
        out_ready_i <= (stall_timer % 24 < 4);
      end
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_valid[i] = 1'b0;
      slot_rank[i]  = 0;
    end
    fill_count     = 0;
    capacity_reg   = 5'd16;
    mismatch_count = 0;
    burst_left     = 0;
    stall_timer    = 0;
    stall_mode     = 0;
    cycle_count    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_eviction();
    test_capacity_bounds();
    test_random_traffic(5'd16, 80);
    test_random_traffic(5'd1, 60);
    test_random_traffic(5'd31, 70);
    test_random_traffic(5'd4, 70);
    test_random_traffic(5'd0, 50);
    test_random_traffic(CAP_W'($urandom_range(2, 15)), 80);
    test_random_traffic(5'd16, 90);

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
